// File: hdl/hda_pkg.sv
package hda_pkg;

  // Fixed field widths
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned SERIES_W = 7;
  localparam int unsigned WINDOW_W = 6;
  localparam int unsigned POS_W    = 6;

  // Default sizing
  localparam int unsigned MAX_SERIES_DEF = 64;
  localparam int unsigned MAX_WINDOW_DEF = 32;
  localparam int unsigned SUM_W_DEF      = SAMPLE_W + $clog2(MAX_WINDOW_DEF);

  // Register map
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SERIES_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'b1;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_DRAIN,
    ST_READ,
    ST_LOAD,
    ST_DIV
  } state_e;

endpackage

// File: hdl/hda_div.sv
module hda_div #(
  parameter int unsigned SumW = hda_pkg::SUM_W_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [SumW-1:0]            dividend_i,
  input  logic [hda_pkg::WINDOW_W-1:0]      divisor_i,
  output logic                              done_o,
  output logic signed [hda_pkg::SAMPLE_W-1:0] quotient_o
);
  import hda_pkg::*;

  localparam int unsigned CntW = $clog2(SumW + 1);

  logic [SumW-1:0]     quo_q, quo_d;
  logic [WINDOW_W-1:0] rem_q, rem_d;
  logic [WINDOW_W-1:0] dsr_q;
  logic                neg_q;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;

  logic [WINDOW_W:0]   rem_sh;
  logic [WINDOW_W:0]   rem_sub;
  logic                fits;
  logic [SumW-1:0]     mag;
  logic [SumW-1:0]     quo_signed;

  // Take the magnitude, restore the sign at the end
  assign mag = dividend_i[SumW-1] ? (~dividend_i + 1'b1) : dividend_i;

  // One restoring step per cycle, MSB first
  assign rem_sh  = {rem_q, quo_q[SumW-1]};
  assign fits    = (rem_sh >= {1'b0, dsr_q});
  assign rem_sub = rem_sh - {1'b0, dsr_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      quo_d  = mag;
      rem_d  = '0;
      cnt_d  = CntW'(SumW);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      quo_d = {quo_q[SumW-2:0], fits};
      rem_d = fits ? rem_sub[WINDOW_W-1:0] : rem_sh[WINDOW_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Operand and working registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dsr_q <= divisor_i;
      neg_q <= dividend_i[SumW-1];
    end
  end

  // Truncate toward zero: negate the magnitude quotient
  assign quo_signed = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign quotient_o = quo_signed[SAMPLE_W-1:0];
  assign done_o     = done_q;

endmodule

// File: hdl/hankel_diagonal_averager_unit.sv
// Accumulate: one sample per cycle outside emission and while no register write is
// pending; each sample is summed into its anti-diagonal entry by a read-modify-write
// on the sum memory. Emission: after the final sample, N averages follow; each passes
// a read, a divider load and the one-bit-per-cycle divider, and may wait on output stalls.
// Reset clears counters and valid bits of the sum memory and sets the registers
// (N=64, L=32); any register write clears the current matrix as well.
module hankel_diagonal_averager_unit #(
  parameter int unsigned MAX_SERIES = hda_pkg::MAX_SERIES_DEF,
  parameter int unsigned MAX_WINDOW = hda_pkg::MAX_WINDOW_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Sample channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [hda_pkg::SAMPLE_W-1:0]  sample_i,
  // Result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [hda_pkg::SAMPLE_W-1:0]  average_o,
  output logic [hda_pkg::POS_W-1:0]            position_o,
  output logic                                 last_of_run_o,
  // Register write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [hda_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [hda_pkg::SERIES_W-1:0]         cfg_data_i
);
  import hda_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_SERIES);
  localparam int unsigned RW    = $clog2(MAX_WINDOW);
  localparam int unsigned SUM_W = SAMPLE_W + $clog2(MAX_WINDOW);

  state_e state_q, state_d;

  logic [SERIES_W-1:0] series_q, series_d;
  logic [WINDOW_W-1:0] window_q, window_d;
  logic [RW-1:0]       row_q, row_d;
  logic [AW-1:0]       col_q, col_d;
  logic [AW-1:0]       idx_q, idx_d;

  logic [SERIES_W-1:0] n_eff, l_clamp, l_eff, k_eff;
  logic [SERIES_W-1:0] row_next, col_next;
  logic                col_done, mat_done;
  logic [AW-1:0]       d_addr;

  logic                in_acc, cfg_we;
  logic                sweep_rd, div_start, push, out_free;

  // Pipeline and memory
  logic [SUM_W-1:0]    mem_q [MAX_SERIES];
  logic [SUM_W-1:0]    rdata_q;
  logic                rvalid_q;
  logic [MAX_SERIES-1:0] valid_q, valid_d;
  logic [AW-1:0]       rd_addr;
  logic                s1_valid_q;
  logic [AW-1:0]       s1_addr_q;
  logic [SAMPLE_W-1:0] s1_sample_q;
  logic                wb_valid_q;
  logic [AW-1:0]       wb_addr_q;
  logic [SUM_W-1:0]    wb_sum_q;
  logic                fwd;
  logic [SUM_W-1:0]    base_sum, wr_sum, sweep_sum;

  // Emission
  logic [SERIES_W-1:0] idx_ext, c_a, c_b, c_min;
  logic [WINDOW_W-1:0] cnt_q;
  logic                idx_last;
  logic                div_done;
  logic [SAMPLE_W-1:0] div_quo;

  logic                out_valid_q;
  logic [SAMPLE_W-1:0] average_q;
  logic [POS_W-1:0]    position_q;
  logic                last_q;

  // Effective N, L and K
  always_comb begin
    n_eff = series_q;
    if (series_q == '0) n_eff = SERIES_W'(1);
    if (series_q > SERIES_W'(MAX_SERIES)) n_eff = SERIES_W'(MAX_SERIES);
    l_clamp = SERIES_W'(window_q);
    if (window_q == '0) l_clamp = SERIES_W'(1);
    if (window_q > WINDOW_W'(MAX_WINDOW)) l_clamp = SERIES_W'(MAX_WINDOW);
    l_eff = (l_clamp > n_eff) ? n_eff : l_clamp;
    k_eff = n_eff - l_eff + 1'b1;
  end

  // Matrix position of the incoming sample
  assign row_next = SERIES_W'(row_q) + 1'b1;
  assign col_next = SERIES_W'(col_q) + 1'b1;
  assign col_done = (row_next >= l_eff);
  assign mat_done = col_done && (col_next >= k_eff);
  assign d_addr   = AW'(SERIES_W'(row_q) + SERIES_W'(col_q));

  assign in_acc = in_valid_i && !in_stall_o;
  assign cfg_we = cfg_valid_i && cfg_ready_o;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_ACC:   if (in_acc && mat_done) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_READ;
      ST_READ:  state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_DIV;
      ST_DIV:   if (push) state_d = idx_last ? ST_ACC : ST_READ;
      default:  state_d = ST_ACC;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall_o  = 1'b1;
    cfg_ready_o = 1'b0;
    sweep_rd    = 1'b0;
    div_start   = 1'b0;
    push        = 1'b0;
    case (state_q)
      ST_ACC: begin
        in_stall_o  = cfg_valid_i;
        cfg_ready_o = 1'b1;
      end
      ST_READ: sweep_rd  = 1'b1;
      ST_LOAD: div_start = 1'b1;
      ST_DIV:  push      = div_done && out_free;
      default: ;
    endcase
  end

  // Registers and counters
  always_comb begin
    series_d = series_q;
    window_d = window_q;
    row_d    = row_q;
    col_d    = col_q;
    idx_d    = idx_q;
    if (cfg_we) begin
      case (cfg_index_i)
        CFG_SERIES_LENGTH: series_d = cfg_data_i;
        CFG_WINDOW_LENGTH: window_d = cfg_data_i[WINDOW_W-1:0];
        default: ;
      endcase
      row_d = '0;
      col_d = '0;
      idx_d = '0;
    end else if (in_acc) begin
      if (col_done) begin
        row_d = '0;
        col_d = mat_done ? '0 : col_next[AW-1:0];
      end else begin
        row_d = row_next[RW-1:0];
      end
    end
    if (push) idx_d = idx_last ? '0 : idx_q + 1'b1;
  end

  // Valid bits: set on write-back, drop on sweep read, clear on register write
  always_comb begin
    valid_d = valid_q;
    if (cfg_we) begin
      valid_d = '0;
    end else begin
      if (s1_valid_q) valid_d[s1_addr_q] = 1'b1;
      if (sweep_rd)   valid_d[idx_q]     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      series_q    <= SERIES_W'(64);
      window_q    <= WINDOW_W'(32);
      row_q       <= '0;
      col_q       <= '0;
      idx_q       <= '0;
      valid_q     <= '0;
      s1_valid_q  <= 1'b0;
      wb_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      series_q    <= series_d;
      window_q    <= window_d;
      row_q       <= row_d;
      col_q       <= col_d;
      idx_q       <= idx_d;
      valid_q     <= valid_d;
      s1_valid_q  <= in_acc;
      wb_valid_q  <= s1_valid_q && !cfg_we;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Sum memory: one write port, one registered read port
  assign rd_addr = (state_q == ST_ACC) ? d_addr : idx_q;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) mem_q[s1_addr_q] <= wr_sum;
    rdata_q  <= mem_q[rd_addr];
    rvalid_q <= valid_q[rd_addr];
  end

  // Accumulate stage; forward the previous write when it hits the same entry
  assign fwd      = wb_valid_q && (wb_addr_q == s1_addr_q);
  assign base_sum = fwd ? wb_sum_q : (rvalid_q ? rdata_q : '0);
  assign wr_sum   = base_sum + {{(SUM_W-SAMPLE_W){s1_sample_q[SAMPLE_W-1]}}, s1_sample_q};

  always_ff @(posedge clk_i) begin
    s1_addr_q   <= d_addr;
    s1_sample_q <= sample_i;
    wb_addr_q   <= s1_addr_q;
    wb_sum_q    <= wr_sum;
  end

  // Element count of the diagonal: min(i+1, L, K, N-i)
  assign idx_ext  = SERIES_W'(idx_q);
  assign idx_last = ((idx_ext + 1'b1) == n_eff);
  assign c_a      = ((idx_ext + 1'b1) < l_eff) ? (idx_ext + 1'b1) : l_eff;
  assign c_b      = (k_eff < (n_eff - idx_ext)) ? k_eff : (n_eff - idx_ext);
  assign c_min    = (c_a < c_b) ? c_a : c_b;
  assign sweep_sum = rvalid_q ? rdata_q : '0;

  always_ff @(posedge clk_i) begin
    if (sweep_rd) cnt_q <= c_min[WINDOW_W-1:0];
  end

  hda_div #(
    .SumW(SUM_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sweep_sum),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      average_q  <= div_quo;
      position_q <= POS_W'(idx_q);
      last_q     <= idx_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign average_o     = average_q;
  assign position_o    = position_q;
  assign last_of_run_o = last_q;

  // Checks
  a_fwd_short_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && fwd) |-> (l_eff <= SERIES_W'(2)))
    else $error("forwarding hit with window longer than two");

  a_no_write_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (state_q == ST_ACC || state_q == ST_DRAIN))
    else $error("sum write during emission");

  a_out_from_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DIV && div_done))
    else $error("result without finished division");

  a_last_ends_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q == ST_DIV) && state_q == ST_ACC) |-> (out_valid_q && last_q))
    else $error("emission ended without last flag");

endmodule
